@@ design/uvsg_pkg.sv @@
// ----------------------------------------------------------------------------
// uvsg_pkg: shared constants, types and helpers for the UV sphere generator
// Fixed widths of the vertex fields, CORDIC table and register map.
// ----------------------------------------------------------------------------
package uvsg_pkg;

  localparam int SEG_W        = 11;
  localparam int RING_W       = 9;
  localparam int PHASE_W      = 32;
  localparam int Q14_W        = 16;
  localparam int POS_W        = 32;
  localparam int RAD_W        = 31;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int PROD_W       = 32;
  localparam int RPROD_W      = 48;
  localparam int MIN_SEGMENTS = 4;
  localparam int MAX_SEGMENTS = 1024;
  localparam int RESET_SEGMENTS = 16;
  localparam int RESET_RADIUS = 65536;
  localparam int DIV_STAGES   = SEG_W + PHASE_W;
  localparam int CORDIC_STEPS = 20;
  localparam int CX_W         = 34;
  localparam int CZ_W         = 32;
  localparam int WIDE_W       = 34;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [Q14_W-1:0] Q14_POS_ONE = 16'sd16384;
  localparam logic signed [Q14_W-1:0] Q14_NEG_ONE = -16'sd16384;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_SEGMENTS = 3'd0;
  localparam logic [2:0] REG_RADIUS   = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_CENTER_Z = 3'd4;

  // quadrant codes taken from the top phase bits
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic vld;
    logic last;
  } ctl_t;

  // arctangent of 2^-i, one turn = 2^32
  function automatic logic signed [CZ_W-1:0] atan_turn(input int i);
    logic signed [CZ_W-1:0] r;
    case (i)
      0:       r = 32'sh20000000;
      1:       r = 32'sh12E4051E;
      2:       r = 32'sh09FB385B;
      3:       r = 32'sh051111D4;
      4:       r = 32'sh028B0D43;
      5:       r = 32'sh0145D7E1;
      6:       r = 32'sh00A2F61E;
      7:       r = 32'sh00517C55;
      8:       r = 32'sh0028BE53;
      9:       r = 32'sh00145F2F;
      10:      r = 32'sh000A2F98;
      11:      r = 32'sh000517CC;
      12:      r = 32'sh00028BE6;
      13:      r = 32'sh000145F3;
      14:      r = 32'sh0000A2FA;
      15:      r = 32'sh0000517D;
      16:      r = 32'sh000028BE;
      17:      r = 32'sh0000145F;
      18:      r = 32'sh00000A30;
      19:      r = 32'sh00000518;
      default: r = '0;
    endcase
    return r;
  endfunction

  // saturate to the Q1.14 unit range
  function automatic logic signed [Q14_W-1:0] clamp_q14(input logic signed [WIDE_W-1:0] v);
    logic signed [Q14_W-1:0] r;
    if (v > WIDE_W'(signed'(Q14_POS_ONE))) begin
      r = Q14_POS_ONE;
    end else if (v < WIDE_W'(signed'(Q14_NEG_ONE))) begin
      r = Q14_NEG_ONE;
    end else begin
      r = v[Q14_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/uvsg_phase.sv @@
// ----------------------------------------------------------------------------
// uvsg_phase: pipelined angle-to-phase divider
// Computes floor(k * 2^32 / p) mod 2^32 for two indexes, one quotient or
// remainder bit per stage (restoring division, 43 stages).
// ----------------------------------------------------------------------------
module uvsg_phase (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  uvsg_pkg::ctl_t                 in_ctl,
  input  logic [uvsg_pkg::SEG_W-1:0]     k_lon,
  input  logic [uvsg_pkg::SEG_W-1:0]     k_lat,
  input  logic [uvsg_pkg::SEG_W-1:0]     p,
  output uvsg_pkg::ctl_t                 out_ctl,
  output logic [uvsg_pkg::PHASE_W-1:0]   phase_lon,
  output logic [uvsg_pkg::PHASE_W-1:0]   phase_lat
);

  localparam int N  = uvsg_pkg::DIV_STAGES;
  localparam int KW = uvsg_pkg::SEG_W;
  localparam int QW = uvsg_pkg::PHASE_W;

  uvsg_pkg::ctl_t ctl_r [0:N-1];
  uvsg_pkg::ctl_t ctl_n [0:N-1];
  logic [KW-1:0]  k_r   [0:N-1][0:1];
  logic [KW-1:0]  k_n   [0:N-1][0:1];
  logic [KW-1:0]  rem_r [0:N-1][0:1];
  logic [KW-1:0]  rem_n [0:N-1][0:1];
  logic [QW-1:0]  quo_r [0:N-1][0:1];
  logic [QW-1:0]  quo_n [0:N-1][0:1];

  // one division step per stage: shift in the next numerator bit, trial subtract
  always_comb begin
    logic [KW-1:0] ka, ra;
    logic [QW-1:0] qa;
    logic [KW:0]   trial;
    logic [KW:0]   diff;
    logic          qb;
    for (int s = 0; s < N; s++) begin
      ctl_n[s] = (s == 0) ? in_ctl : ctl_r[s-1];
      for (int l = 0; l < 2; l++) begin
        if (s == 0) begin
          ka = (l == 0) ? k_lon : k_lat;
          ra = '0;
          qa = '0;
        end else begin
          ka = k_r[s-1][l];
          ra = rem_r[s-1][l];
          qa = quo_r[s-1][l];
        end
        trial = {ra, ka[KW-1]};
        diff  = trial - {1'b0, p};
        qb    = (trial >= {1'b0, p});
        k_n[s][l]   = {ka[KW-2:0], 1'b0};
        rem_n[s][l] = qb ? diff[KW-1:0] : trial[KW-1:0];
        quo_n[s][l] = (s >= KW) ? {qa[QW-2:0], qb} : qa;
      end
    end
  end

  // advance control with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < N; s++) ctl_r[s] <= '0;
    end else if (en) begin
      for (int s = 0; s < N; s++) ctl_r[s] <= ctl_n[s];
    end
  end

  // advance data
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < N; s++) begin
        for (int l = 0; l < 2; l++) begin
          k_r[s][l]   <= k_n[s][l];
          rem_r[s][l] <= rem_n[s][l];
          quo_r[s][l] <= quo_n[s][l];
        end
      end
    end
  end

  assign out_ctl   = ctl_r[N-1];
  assign phase_lon = quo_r[N-1][0];
  assign phase_lat = quo_r[N-1][1];

endmodule

@@ design/uvsg_cordic.sv @@
// ----------------------------------------------------------------------------
// uvsg_cordic: two-lane pipelined CORDIC sine/cosine
// 20 rotation stages in the first quadrant, then one stage that rounds,
// clamps to Q1.14 and restores the quadrant.
// ----------------------------------------------------------------------------
module uvsg_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  uvsg_pkg::ctl_t                      in_ctl,
  input  logic [uvsg_pkg::PHASE_W-1:0]        phase_lon,
  input  logic [uvsg_pkg::PHASE_W-1:0]        phase_lat,
  output uvsg_pkg::ctl_t                      out_ctl,
  output logic signed [uvsg_pkg::Q14_W-1:0]   sin_lon,
  output logic signed [uvsg_pkg::Q14_W-1:0]   cos_lon,
  output logic signed [uvsg_pkg::Q14_W-1:0]   sin_lat,
  output logic signed [uvsg_pkg::Q14_W-1:0]   cos_lat
);

  localparam int N  = uvsg_pkg::CORDIC_STEPS;
  localparam int XW = uvsg_pkg::CX_W;
  localparam int ZW = uvsg_pkg::CZ_W;
  localparam int QW = uvsg_pkg::Q14_W;
  localparam int WW = uvsg_pkg::WIDE_W;

  uvsg_pkg::ctl_t        ctl_r [0:N-1];
  uvsg_pkg::ctl_t        ctl_n [0:N-1];
  logic signed [XW-1:0]  x_r   [0:N-1][0:1];
  logic signed [XW-1:0]  x_n   [0:N-1][0:1];
  logic signed [XW-1:0]  y_r   [0:N-1][0:1];
  logic signed [XW-1:0]  y_n   [0:N-1][0:1];
  logic signed [ZW-1:0]  z_r   [0:N-1][0:1];
  logic signed [ZW-1:0]  z_n   [0:N-1][0:1];
  logic [1:0]            q_r   [0:N-1][0:1];
  logic [1:0]            q_n   [0:N-1][0:1];

  uvsg_pkg::ctl_t        fin_ctl;
  logic signed [QW-1:0]  fin_s [0:1];
  logic signed [QW-1:0]  fin_c [0:1];
  logic signed [QW-1:0]  s_n   [0:1];
  logic signed [QW-1:0]  c_n   [0:1];

  // rotation steps
  always_comb begin
    logic signed [XW-1:0] xa, ya;
    logic signed [ZW-1:0] za;
    logic [1:0]           qa;
    logic [uvsg_pkg::PHASE_W-1:0] ph;
    for (int s = 0; s < N; s++) begin
      ctl_n[s] = (s == 0) ? in_ctl : ctl_r[s-1];
      for (int l = 0; l < 2; l++) begin
        if (s == 0) begin
          ph = (l == 0) ? phase_lon : phase_lat;
          xa = uvsg_pkg::CORDIC_GAIN;
          ya = '0;
          za = signed'({2'b00, ph[uvsg_pkg::PHASE_W-3:0]});
          qa = ph[uvsg_pkg::PHASE_W-1 -: 2];
        end else begin
          xa = x_r[s-1][l];
          ya = y_r[s-1][l];
          za = z_r[s-1][l];
          qa = q_r[s-1][l];
        end
        if (!za[ZW-1]) begin
          x_n[s][l] = xa - (ya >>> s);
          y_n[s][l] = ya + (xa >>> s);
          z_n[s][l] = za - uvsg_pkg::atan_turn(s);
        end else begin
          x_n[s][l] = xa + (ya >>> s);
          y_n[s][l] = ya - (xa >>> s);
          z_n[s][l] = za + uvsg_pkg::atan_turn(s);
        end
        q_n[s][l] = qa;
      end
    end
  end

  // round, clamp and unfold the quadrant
  always_comb begin
    logic signed [WW-1:0] xr, yr;
    logic signed [QW-1:0] cr, sr;
    for (int l = 0; l < 2; l++) begin
      xr = (x_r[N-1][l] + XW'(32768)) >>> 16;
      yr = (y_r[N-1][l] + XW'(32768)) >>> 16;
      cr = uvsg_pkg::clamp_q14(xr);
      sr = uvsg_pkg::clamp_q14(yr);
      case (q_r[N-1][l])
        uvsg_pkg::QUAD_0: begin c_n[l] = cr;  s_n[l] = sr;  end
        uvsg_pkg::QUAD_1: begin c_n[l] = -sr; s_n[l] = cr;  end
        uvsg_pkg::QUAD_2: begin c_n[l] = -cr; s_n[l] = -sr; end
        default:          begin c_n[l] = sr;  s_n[l] = -cr; end
      endcase
    end
  end

  // advance control
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < N; s++) ctl_r[s] <= '0;
      fin_ctl <= '0;
    end else if (en) begin
      for (int s = 0; s < N; s++) ctl_r[s] <= ctl_n[s];
      fin_ctl <= ctl_r[N-1];
    end
  end

  // advance data
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < N; s++) begin
        for (int l = 0; l < 2; l++) begin
          x_r[s][l] <= x_n[s][l];
          y_r[s][l] <= y_n[s][l];
          z_r[s][l] <= z_n[s][l];
          q_r[s][l] <= q_n[s][l];
        end
      end
      for (int l = 0; l < 2; l++) begin
        fin_s[l] <= s_n[l];
        fin_c[l] <= c_n[l];
      end
    end
  end

  assign out_ctl = fin_ctl;
  assign sin_lon = fin_s[0];
  assign cos_lon = fin_c[0];
  assign sin_lat = fin_s[1];
  assign cos_lat = fin_c[1];

endmodule

@@ design/uv_sphere_vertex_generator.sv @@
// Throughput: one vertex beat per cycle unless vertex_ready stalls; the single vertex
//   issue slot per cycle limits index beats, each beat producing two vertices.
// Depth: 43 divider stages (phase), 21 CORDIC stages, 4 multiply/output stages.
// Reset: synchronous; clears all valid bits and loads segments=16, radius=1.0,
//   center=0. No clearing pass; the block takes beats from the first cycle after.
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator: UV sphere vertex pipeline
// Turns a (ring, segment) beat into lower and upper ring vertices with
// normal, tangent, binormal and saturated position.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [uvsg_pkg::ADDR_W-1:0]         paddr,
  input  logic [uvsg_pkg::DATA_W-1:0]         pwdata,
  output logic [uvsg_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  // index beats
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [uvsg_pkg::RING_W-1:0]         ring,
  input  logic [uvsg_pkg::SEG_W-1:0]          segment,
  // vertex beats
  output logic                                vertex_valid,
  input  logic                                vertex_ready,
  output logic signed [uvsg_pkg::Q14_W-1:0]   tangent_x,
  output logic signed [uvsg_pkg::Q14_W-1:0]   tangent_z,
  output logic signed [uvsg_pkg::Q14_W-1:0]   binormal_x,
  output logic signed [uvsg_pkg::Q14_W-1:0]   binormal_y,
  output logic signed [uvsg_pkg::Q14_W-1:0]   binormal_z,
  output logic signed [uvsg_pkg::Q14_W-1:0]   normal_x,
  output logic signed [uvsg_pkg::Q14_W-1:0]   normal_y,
  output logic signed [uvsg_pkg::Q14_W-1:0]   normal_z,
  output logic signed [uvsg_pkg::POS_W-1:0]   position_x,
  output logic signed [uvsg_pkg::POS_W-1:0]   position_y,
  output logic signed [uvsg_pkg::POS_W-1:0]   position_z,
  output logic                                last
);

  localparam int QW = uvsg_pkg::Q14_W;
  localparam int PW = uvsg_pkg::POS_W;
  localparam int MW = uvsg_pkg::PROD_W;
  localparam int RW = uvsg_pkg::RPROD_W;
  localparam int SW = uvsg_pkg::SEG_W;

  // ---------------- configuration registers ----------------
  logic [SW-1:0]                  segments;
  logic [uvsg_pkg::RAD_W-1:0]     radius;
  logic signed [PW-1:0]           center_x, center_y, center_z;
  logic                           cfg_wr;
  logic [2:0]                     cfg_idx;
  logic [SW-1:0]                  seg_eff;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[uvsg_pkg::ADDR_W-1:2];

  // write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      segments <= SW'(uvsg_pkg::RESET_SEGMENTS);
      radius   <= uvsg_pkg::RAD_W'(uvsg_pkg::RESET_RADIUS);
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        uvsg_pkg::REG_SEGMENTS: segments <= pwdata[SW-1:0];
        uvsg_pkg::REG_RADIUS:   radius   <= pwdata[uvsg_pkg::RAD_W-1:0];
        uvsg_pkg::REG_CENTER_X: center_x <= pwdata;
        uvsg_pkg::REG_CENTER_Y: center_y <= pwdata;
        uvsg_pkg::REG_CENTER_Z: center_z <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (cfg_idx)
      uvsg_pkg::REG_SEGMENTS: prdata = uvsg_pkg::DATA_W'(segments);
      uvsg_pkg::REG_RADIUS:   prdata = uvsg_pkg::DATA_W'(radius);
      uvsg_pkg::REG_CENTER_X: prdata = center_x;
      uvsg_pkg::REG_CENTER_Y: prdata = center_y;
      uvsg_pkg::REG_CENTER_Z: prdata = center_z;
      default:                prdata = '0;
    endcase
  end

  // clamp the segment count into range
  always_comb begin
    if (segments < SW'(uvsg_pkg::MIN_SEGMENTS)) begin
      seg_eff = SW'(uvsg_pkg::MIN_SEGMENTS);
    end else if (segments > SW'(uvsg_pkg::MAX_SEGMENTS)) begin
      seg_eff = SW'(uvsg_pkg::MAX_SEGMENTS);
    end else begin
      seg_eff = segments;
    end
  end

  // ---------------- issue: one beat becomes two vertex jobs ----------------
  logic                             adv;
  logic                             busy, half;
  logic [uvsg_pkg::RING_W-1:0]      hold_ring;
  logic [SW-1:0]                    hold_seg;
  uvsg_pkg::ctl_t                   job_ctl;
  logic [SW-1:0]                    job_seg;
  logic [SW-1:0]                    job_ring;
  logic                             item_fire;

  assign adv        = !vertex_valid || vertex_ready;
  assign item_ready = adv && (!busy || half);
  assign item_fire  = item_valid && item_ready;

  // hold the beat, issue lower then upper job
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      half    <= 1'b0;
      job_ctl <= '0;
    end else if (adv) begin
      job_ctl.vld  <= busy;
      job_ctl.last <= half;
      if (!busy || half) begin
        busy <= item_valid;
        half <= 1'b0;
      end else begin
        half <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      hold_ring <= ring;
      hold_seg  <= segment;
    end
    if (adv) begin
      job_seg  <= hold_seg;
      job_ring <= half ? SW'(hold_ring) + SW'(1) : SW'(hold_ring);
    end
  end

  // ---------------- phase and trig ----------------
  uvsg_pkg::ctl_t                 ph_ctl;
  logic [uvsg_pkg::PHASE_W-1:0]   ph_lon, ph_lat;
  uvsg_pkg::ctl_t                 tr_ctl;
  logic signed [QW-1:0]           sb, cb, sa, ca;

  uvsg_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_ctl    (job_ctl),
    .k_lon     (job_seg),
    .k_lat     (job_ring),
    .p         (seg_eff),
    .out_ctl   (ph_ctl),
    .phase_lon (ph_lon),
    .phase_lat (ph_lat)
  );

  uvsg_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_ctl    (ph_ctl),
    .phase_lon (ph_lon),
    .phase_lat (ph_lat),
    .out_ctl   (tr_ctl),
    .sin_lon   (sb),
    .cos_lon   (cb),
    .sin_lat   (sa),
    .cos_lat   (ca)
  );

  // ---------------- vector products ----------------
  uvsg_pkg::ctl_t         m1_ctl, m2_ctl, m3_ctl, out_ctl;
  logic signed [QW-1:0]   m1_sb, m1_cb, m1_sa, m1_ca;
  logic signed [MW-1:0]   m1_pnx, m1_pnz, m1_pbx, m1_pbz;
  logic signed [QW-1:0]   m2_sb, m2_cb, m2_sa, m2_nx, m2_ny, m2_nz, m2_bx, m2_bz;
  logic signed [QW-1:0]   m3_sb, m3_cb, m3_sa, m3_nx, m3_ny, m3_nz, m3_bx, m3_bz;
  logic signed [RW-1:0]   m3_rx, m3_ry, m3_rz;
  logic signed [PW-1:0]   pos_x_next, pos_y_next, pos_z_next;

  function automatic logic signed [QW-1:0] round_q14(input logic signed [MW-1:0] v);
    logic signed [uvsg_pkg::WIDE_W-1:0] w;
    w = (uvsg_pkg::WIDE_W'(v) + uvsg_pkg::WIDE_W'(8192)) >>> 14;
    return uvsg_pkg::clamp_q14(w);
  endfunction

  function automatic logic signed [PW-1:0] place(input logic signed [PW-1:0] c,
                                                 input logic signed [RW-1:0] r);
    logic signed [RW-1:0] sh;
    logic signed [PW+2:0] t;
    logic signed [PW-1:0] o;
    sh = (r + RW'(8192)) >>> 14;
    t  = signed'(sh[PW+2:0]) + (PW+3)'(c);
    if (t > (PW+3)'(signed'({1'b0, {(PW-1){1'b1}}}))) begin
      o = {1'b0, {(PW-1){1'b1}}};
    end else if (t < (PW+3)'(signed'({1'b1, {(PW-1){1'b0}}}))) begin
      o = {1'b1, {(PW-1){1'b0}}};
    end else begin
      o = t[PW-1:0];
    end
    return o;
  endfunction

  assign pos_x_next = place(center_x, m3_rx);
  assign pos_y_next = place(center_y, m3_ry);
  assign pos_z_next = place(center_z, m3_rz);

  // advance control of the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_ctl  <= '0;
      m2_ctl  <= '0;
      m3_ctl  <= '0;
      out_ctl <= '0;
    end else if (adv) begin
      m1_ctl  <= tr_ctl;
      m2_ctl  <= m1_ctl;
      m3_ctl  <= m2_ctl;
      out_ctl <= m3_ctl;
    end
  end

  // multiply, round, scale, place
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_sb  <= sb;
      m1_cb  <= cb;
      m1_sa  <= sa;
      m1_ca  <= ca;
      m1_pnx <= MW'(sa) * MW'(cb);
      m1_pnz <= MW'(sa) * MW'(sb);
      m1_pbx <= MW'(ca) * MW'(cb);
      m1_pbz <= MW'(ca) * MW'(sb);

      m2_sb <= m1_sb;
      m2_cb <= m1_cb;
      m2_sa <= m1_sa;
      m2_nx <= round_q14(m1_pnx);
      m2_ny <= -m1_ca;
      m2_nz <= round_q14(m1_pnz);
      m2_bx <= round_q14(m1_pbx);
      m2_bz <= round_q14(m1_pbz);

      m3_sb <= m2_sb;
      m3_cb <= m2_cb;
      m3_sa <= m2_sa;
      m3_nx <= m2_nx;
      m3_ny <= m2_ny;
      m3_nz <= m2_nz;
      m3_bx <= m2_bx;
      m3_bz <= m2_bz;
      m3_rx <= RW'(signed'({1'b0, radius})) * RW'(m2_nx);
      m3_ry <= RW'(signed'({1'b0, radius})) * RW'(m2_ny);
      m3_rz <= RW'(signed'({1'b0, radius})) * RW'(m2_nz);

      tangent_x  <= m3_sb;
      tangent_z  <= -m3_cb;
      binormal_x <= m3_bx;
      binormal_y <= m3_sa;
      binormal_z <= m3_bz;
      normal_x   <= m3_nx;
      normal_y   <= m3_ny;
      normal_z   <= m3_nz;
      position_x <= pos_x_next;
      position_y <= pos_y_next;
      position_z <= pos_z_next;
    end
  end

  assign vertex_valid = out_ctl.vld;
  assign last         = out_ctl.last;

  // ---------------- assertions ----------------
  // a beat taken while a beat is held means the held one's upper job goes out
  a_upper_on_take: assert property (@(posedge clk) disable iff (rst)
    item_fire && busy |=> job_ctl.vld && job_ctl.last)
    else $error("upper job not issued when next beat was taken");

  // a lower job is followed directly by its upper job
  a_job_pair: assert property (@(posedge clk) disable iff (rst)
    adv && job_ctl.vld && !job_ctl.last |=> job_ctl.vld && job_ctl.last)
    else $error("lower job not followed by upper job");

  // a lower vertex beat is followed directly by the upper vertex
  a_vertex_pair: assert property (@(posedge clk) disable iff (rst)
    vertex_valid && vertex_ready && !last |=> vertex_valid && last)
    else $error("upper vertex did not follow lower vertex");

endmodule

@@ sim/uv_sphere_vertex_generator_tb.sv @@
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_tb: self-checking bench for the UV sphere pipeline
// Drives ring/segment beats under several register settings and idle patterns,
// predicts both ring vertices of every beat and checks each vertex beat.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 90;

  typedef struct {
    logic signed [uvsg_pkg::Q14_W-1:0] tan_x, tan_z, bin_x, bin_y, bin_z;
    logic signed [uvsg_pkg::Q14_W-1:0] nrm_x, nrm_y, nrm_z;
    logic signed [uvsg_pkg::POS_W-1:0] pos_x, pos_y, pos_z;
    logic                              upper;
  } vertex_t;

  // Sphere vertex predictor plus the queue of vertices still owed.
  class vertex_scoreboard;
    int unsigned seg_reg;
    longint      rad_reg;
    int          cen_x, cen_y, cen_z;
    vertex_t     expected_vertices[$];
    int          mismatches;
    int          vertices_checked;
    int          indexes_taken;
    longint      atan_tab[uvsg_pkg::CORDIC_STEPS] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
      'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
      'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
      'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518};

    function new();
      seg_reg = uvsg_pkg::RESET_SEGMENTS;
      rad_reg = uvsg_pkg::RESET_RADIUS;
      cen_x = 0;
      cen_y = 0;
      cen_z = 0;
      mismatches = 0;
      vertices_checked = 0;
      indexes_taken = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        uvsg_pkg::REG_SEGMENTS: seg_reg = 32'(v[10:0]);
        uvsg_pkg::REG_RADIUS:   rad_reg = 64'(v[30:0]);
        uvsg_pkg::REG_CENTER_X: cen_x = signed'(v);
        uvsg_pkg::REG_CENTER_Y: cen_y = signed'(v);
        uvsg_pkg::REG_CENTER_Z: cen_z = signed'(v);
        default: ;
      endcase
    endfunction

    function int unsigned eff_segments();
      if (seg_reg < uvsg_pkg::MIN_SEGMENTS) return uvsg_pkg::MIN_SEGMENTS;
      if (seg_reg > uvsg_pkg::MAX_SEGMENTS) return uvsg_pkg::MAX_SEGMENTS;
      return seg_reg;
    endfunction

    function int unit_clamp(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return int'(v);
    endfunction

    function logic [31:0] turn_phase(int unsigned k, int unsigned p);
      logic [63:0] num;
      num = 64'(k % p) << 32;
      return 32'(num / p);
    endfunction

    // Rotate through 20 steps inside the quadrant, then restore the quadrant.
    function void sin_cos(logic [31:0] ph, output int s, output int c);
      longint x, y, z, dx, dy;
      int cr, sr;
      x = 652032874;
      y = 0;
      z = longint'(ph[29:0]);
      for (int i = 0; i < uvsg_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[i];
        end else begin
          x += dx; y -= dy; z += atan_tab[i];
        end
      end
      cr = unit_clamp((x + 32768) >>> 16);
      sr = unit_clamp((y + 32768) >>> 16);
      case (ph[31:30])
        uvsg_pkg::QUAD_0: begin c = cr;  s = sr;  end
        uvsg_pkg::QUAD_1: begin c = -sr; s = cr;  end
        uvsg_pkg::QUAD_2: begin c = -cr; s = -sr; end
        default: begin c = sr; s = -cr; end
      endcase
    endfunction

    function int q14_mul(int a, int b);
      return unit_clamp((longint'(a) * longint'(b) + 8192) >>> 14);
    endfunction

    function logic signed [31:0] place(int centre, int n);
      longint v;
      v = longint'(centre) + ((rad_reg * longint'(n) + 8192) >>> 14);
      if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
      if (v < -64'sh80000000) v = -64'sh80000000;
      return 32'(v);
    endfunction

    function vertex_t ring_vertex(int unsigned k, int sb, int cb, int unsigned p, bit up);
      vertex_t vx;
      int sa, ca, nx, ny, nz;
      sin_cos(turn_phase(k, p), sa, ca);
      nx = q14_mul(sa, cb);
      ny = -ca;
      nz = q14_mul(sa, sb);
      vx.tan_x = 16'(sb);
      vx.tan_z = 16'(-cb);
      vx.bin_x = 16'(q14_mul(ca, cb));
      vx.bin_y = 16'(sa);
      vx.bin_z = 16'(q14_mul(ca, sb));
      vx.nrm_x = 16'(nx);
      vx.nrm_y = 16'(ny);
      vx.nrm_z = 16'(nz);
      vx.pos_x = place(cen_x, nx);
      vx.pos_y = place(cen_y, ny);
      vx.pos_z = place(cen_z, nz);
      vx.upper = up;
      return vx;
    endfunction

    // Queue the lower then the upper ring vertex of an accepted index beat.
    function void note_index(logic [uvsg_pkg::RING_W-1:0] r,
                             logic [uvsg_pkg::SEG_W-1:0] s);
      int unsigned p;
      int sb, cb;
      p = eff_segments();
      sin_cos(turn_phase(32'(s), p), sb, cb);
      expected_vertices.push_back(ring_vertex(32'(r), sb, cb, p, 1'b0));
      expected_vertices.push_back(ring_vertex(32'(r) + 1, sb, cb, p, 1'b1));
      indexes_taken++;
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s: expected %0d, got %0d", name, e, a);
        mismatches++;
      end
    endfunction

    function void check_vertex(vertex_t a);
      vertex_t e;
      if (expected_vertices.size() == 0) begin
        $error("vertex beat with nothing expected");
        mismatches++;
        return;
      end
      e = expected_vertices.pop_front();
      vertices_checked++;
      cmp("tangent_x", longint'(e.tan_x), longint'(a.tan_x));
      cmp("tangent_z", longint'(e.tan_z), longint'(a.tan_z));
      cmp("binormal_x", longint'(e.bin_x), longint'(a.bin_x));
      cmp("binormal_y", longint'(e.bin_y), longint'(a.bin_y));
      cmp("binormal_z", longint'(e.bin_z), longint'(a.bin_z));
      cmp("normal_x", longint'(e.nrm_x), longint'(a.nrm_x));
      cmp("normal_y", longint'(e.nrm_y), longint'(a.nrm_y));
      cmp("normal_z", longint'(e.nrm_z), longint'(a.nrm_z));
      cmp("position_x", longint'(e.pos_x), longint'(a.pos_x));
      cmp("position_y", longint'(e.pos_y), longint'(a.pos_y));
      cmp("position_z", longint'(e.pos_z), longint'(a.pos_z));
      cmp("last", longint'(e.upper), longint'(a.upper));
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [uvsg_pkg::ADDR_W-1:0] paddr = '0;
  logic [uvsg_pkg::DATA_W-1:0] pwdata = '0;
  logic [uvsg_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_ready;
  logic [uvsg_pkg::RING_W-1:0] ring = '0;
  logic [uvsg_pkg::SEG_W-1:0] segment = '0;
  logic vertex_valid;
  logic vertex_ready = 1'b0;
  logic signed [uvsg_pkg::Q14_W-1:0] tangent_x, tangent_z;
  logic signed [uvsg_pkg::Q14_W-1:0] binormal_x, binormal_y, binormal_z;
  logic signed [uvsg_pkg::Q14_W-1:0] normal_x, normal_y, normal_z;
  logic signed [uvsg_pkg::POS_W-1:0] position_x, position_y, position_z;
  logic last;

  vertex_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  uv_sphere_vertex_generator i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .item_valid, .item_ready, .ring, .segment,
    .vertex_valid, .vertex_ready, .tangent_x, .tangent_z,
    .binormal_x, .binormal_y, .binormal_z, .normal_x, .normal_y, .normal_z,
    .position_x, .position_y, .position_z, .last
  );

  always #1 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      vertex_ready <= 1'b0;
    end else if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
      vertex_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      vertex_ready <= 1'b0;
    end else begin
      vertex_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Note accepted index beats and check vertex beats.
  always @(posedge clk) begin
    vertex_t got;
    if (!rst) begin
      if (item_valid && item_ready) sb.note_index(ring, segment);
      if (vertex_valid && vertex_ready) begin
        got.tan_x = tangent_x;   got.tan_z = tangent_z;
        got.bin_x = binormal_x;  got.bin_y = binormal_y;  got.bin_z = binormal_z;
        got.nrm_x = normal_x;    got.nrm_y = normal_y;    got.nrm_z = normal_z;
        got.pos_x = position_x;  got.pos_y = position_y;  got.pos_z = position_z;
        got.upper = last;
        sb.check_vertex(got);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= uvsg_pkg::ADDR_W'(idx) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic write_all(logic [31:0] s, logic [31:0] r, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z);
    reg_write(uvsg_pkg::REG_SEGMENTS, s);
    reg_write(uvsg_pkg::REG_RADIUS, r);
    reg_write(uvsg_pkg::REG_CENTER_X, x);
    reg_write(uvsg_pkg::REG_CENTER_Y, y);
    reg_write(uvsg_pkg::REG_CENTER_Z, z);
  endtask

  // Offer one index beat and hold it until taken; call just after a rising edge.
  task automatic send_index(logic [uvsg_pkg::RING_W-1:0] r,
                            logic [uvsg_pkg::SEG_W-1:0] s);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    ring <= r;
    segment <= s;
    do begin
      @(negedge clk);
      taken = item_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Stop offering and wait until every vertex has come back.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed indices for the current segment count, some raw noise.
  task automatic random_indexes(int n, bit mid_pause);
    int unsigned p;
    for (int k = 0; k < n; k++) begin
      p = sb.eff_segments();
      if (mid_pause && k == n / 2) begin
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      if ($urandom_range(99) < 80)
        send_index(uvsg_pkg::RING_W'($urandom_range(p / 2 - 1)),
                   uvsg_pkg::SEG_W'($urandom_range(p)));
      else
        send_index(uvsg_pkg::RING_W'($urandom_range(511)),
                   uvsg_pkg::SEG_W'($urandom_range(2047)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: poles, band edges, wrap of ring and segment.
    send_index(0, 0);
    send_index(0, 16);
    send_index(7, 4);
    send_index(8, 0);
    send_index(15, 17);
    send_index(511, 2047);
    send_index(1, 1);
    send_index(3, 12);
    send_index(0, 8);
    send_index(255, 1024);
    send_index(4, 2);
    random_indexes(240, 1'b0);
    drain();

    // Segments below the minimum, largest radius, saturating centres.
    send_idle_pct = 60;
    write_all(0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, $urandom());
    send_index(0, 0);
    send_index(1, 1);
    send_index(2, 2);
    send_index(1, 4);
    send_index(511, 2047);
    random_indexes(245, 1'b0);
    drain();

    // Segments above the maximum, zero radius; receiver stalls and a long hold.
    send_idle_pct = 0;
    recv_stall_pct = 60;
    write_all(2047, 0, $urandom(), $urandom(), $urandom());
    hold_requests++;
    send_index(511, 1024);
    send_index(0, 2047);
    random_indexes(248, 1'b0);
    drain();

    // Exact maximum, random geometry; both sides idle.
    send_idle_pct = 16;
    recv_stall_pct = 16;
    write_all(1024, $urandom(), $urandom(), $urandom(), $urandom());
    random_indexes(250, 1'b0);
    drain();

    // Just under the minimum, no idling, pause until empty midway.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_all(3, $urandom_range(32'h0100_0000), $urandom(), $urandom(), $urandom());
    random_indexes(250, 1'b1);
    drain();

    // Small random segment counts, sender idling.
    send_idle_pct = 60;
    write_all($urandom_range(4, 64), $urandom(), $urandom(), $urandom(), $urandom());
    random_indexes(250, 1'b0);
    drain();

    $display("covered %0d index beats, %0d vertices, six register settings",
             sb.indexes_taken, sb.vertices_checked);
    $display("idle modes: none, sender, receiver with long hold, both");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/uvsg_pkg.sv
design/uvsg_phase.sv
design/uvsg_cordic.sv
design/uv_sphere_vertex_generator.sv
sim/uv_sphere_vertex_generator_tb.sv
